FILE: hdl/ctdn_pkg.sv
// Shared types, codes and constants for the countdown timer.
`timescale 1ns / 1ps

package ctdn_pkg;

    // Largest set time in seconds
    localparam logic [15:0] MAX_SET_SECONDS = 16'd59999;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_STEP   = 2'd0;
    localparam logic [1:0] CFG_COUNT_PH   = 2'd1;
    localparam logic [1:0] CFG_BEEP_PH    = 2'd2;
    localparam logic [1:0] CFG_STAT_HOLD  = 2'd3;

    // Event codes
    localparam logic [2:0] OP_INC   = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_COUNT = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_STAT  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        OUT_IGNORED    = 2'd0,
        OUT_HANDLED    = 2'd1,
        OUT_TRANSITION = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [11:0] set_step;
        logic [3:0]  count_phase;
        logic [3:0]  beep_phase;
        logic [7:0]  stat_hold;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] remaining;
        logic [31:0] productive;
        logic        beep;
        outcome_t    outcome;
    } result_t;

endpackage

FILE: hdl/countdown_timer_with_pause.sv
// Top level of the countdown timer: event register, update core, result register.
`timescale 1ns / 1ps

// Countdown timer with set, countdown, pause and statistics modes. Each
// accepted event yields exactly one result carrying the mode, remaining
// seconds, productive total, beep flag and outcome after that event. An
// event is captured in an input register, applied to the state by the
// update logic and held in a result register. The result register is
// loaded only while it is free or draining, so a stalled output holds
// the event in the input register. One event is taken every cycle as
// long as results are drained. Throughput is set by the single state
// update per cycle. Write configuration only while no event is in flight.
module countdown_timer_with_pause
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  sub_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  mode,
    output logic [15:0] remaining_seconds,
    output logic [31:0] productive_seconds,
    output logic        beep,
    output logic [1:0]  outcome,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import ctdn_pkg::*;

    cfg_t        cfg;
    result_t     res;
    result_t     res_reg;
    logic        in_vld_reg;
    logic        out_vld_reg;
    logic [2:0]  op_reg;
    logic [3:0]  phase_reg;
    logic        advance;

    ctdn_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctdn_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .op         (op_reg),
        .sub_second (phase_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // Move the held event forward when the result slot is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // Capture the event payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= op;
            phase_reg <= sub_second;
        end
    end

    // Result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid          = out_vld_reg;
    assign mode               = res_reg.mode;
    assign remaining_seconds  = res_reg.remaining;
    assign productive_seconds = res_reg.productive;
    assign beep               = res_reg.beep;
    assign outcome            = res_reg.outcome;

endmodule

FILE: hdl/ctdn_cfg.sv
// Configuration register bank for the countdown timer.
`timescale 1ns / 1ps

module ctdn_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    output ctdn_pkg::cfg_t     cfg
);
    import ctdn_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_step    <= 12'd60;
            cfg_reg.count_phase <= 4'd10;
            cfg_reg.beep_phase  <= 4'd5;
            cfg_reg.stat_hold   <= 8'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_STEP:  cfg_reg.set_step    <= cfg_data;
                CFG_COUNT_PH:  cfg_reg.count_phase <= cfg_data[3:0];
                CFG_BEEP_PH:   cfg_reg.beep_phase  <= cfg_data[3:0];
                CFG_STAT_HOLD: cfg_reg.stat_hold   <= cfg_data[7:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/ctdn_core.sv
// Timer state registers and the per-event update logic.
`timescale 1ns / 1ps

module ctdn_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [2:0]          op,
    input  logic [3:0]          sub_second,
    input  ctdn_pkg::cfg_t      cfg,
    output ctdn_pkg::result_t   res
);
    import ctdn_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] set_seconds_reg, set_seconds_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [31:0] productive_reg, productive_next;
    logic [7:0]  stat_ticks_reg, stat_ticks_next;

    logic [16:0] add_sum;
    logic [15:0] add_sat;
    logic [15:0] step16;
    logic        can_dec;
    logic [7:0]  stat_inc;
    logic [32:0] prod_sum;
    logic        go;
    mode_t       target;
    logic        beep;
    outcome_t    outcome;
    logic [15:0] set_mid;
    logic [15:0] el_mid;

    // Saturating step add and the decrease guard
    assign step16  = {4'd0, cfg.set_step};
    assign add_sum = {1'b0, set_seconds_reg} + {1'b0, step16};
    assign add_sat = (add_sum > {1'b0, MAX_SET_SECONDS}) ? MAX_SET_SECONDS : add_sum[15:0];
    assign can_dec = (set_seconds_reg >= step16);
    assign stat_inc = stat_ticks_reg + 8'd1;

    // Decide the event's effect inside the current state
    always_comb
    begin
        set_mid         = set_seconds_reg;
        el_mid          = elapsed_reg;
        stat_ticks_next = stat_ticks_reg;
        go              = 1'b0;
        target          = MODE_IDLE;
        beep            = 1'b0;
        outcome         = OUT_IGNORED;
        case (mode_reg)
            MODE_SET:
            begin
                case (op)
                    OP_INC:
                    begin
                        set_mid = add_sat;
                        outcome = OUT_HANDLED;
                    end
                    OP_DEC:
                    begin
                        if (can_dec)
                        begin
                            set_mid = set_seconds_reg - step16;
                            outcome = OUT_HANDLED;
                        end
                    end
                    OP_START:
                    begin
                        if (can_dec && set_seconds_reg != 16'd0)
                        begin
                            go      = 1'b1;
                            target  = MODE_COUNT;
                            outcome = OUT_TRANSITION;
                        end
                    end
                    OP_CANCEL:
                    begin
                        go      = 1'b1;
                        target  = MODE_IDLE;
                        outcome = OUT_TRANSITION;
                    end
                    default: ;
                endcase
            end
            MODE_COUNT:
            begin
                case (op)
                    OP_TICK:
                    begin
                        if (sub_second == cfg.count_phase)
                        begin
                            if (set_seconds_reg != 16'd0)
                            begin
                                set_mid = set_seconds_reg - 16'd1;
                                if (elapsed_reg != 16'hFFFF)
                                begin
                                    el_mid = elapsed_reg + 16'd1;
                                end
                            end
                            if (set_mid == 16'd0)
                            begin
                                go      = 1'b1;
                                target  = MODE_IDLE;
                                outcome = OUT_TRANSITION;
                            end
                            else
                            begin
                                outcome = OUT_HANDLED;
                            end
                        end
                    end
                    OP_START:
                    begin
                        go      = 1'b1;
                        target  = MODE_PAUSE;
                        outcome = OUT_TRANSITION;
                    end
                    OP_CANCEL:
                    begin
                        go      = 1'b1;
                        target  = MODE_IDLE;
                        outcome = OUT_TRANSITION;
                    end
                    default: ;
                endcase
            end
            MODE_PAUSE:
            begin
                case (op)
                    OP_INC:
                    begin
                        set_mid = add_sat;
                        go      = 1'b1;
                        target  = MODE_SET;
                        outcome = OUT_TRANSITION;
                    end
                    OP_DEC:
                    begin
                        if (can_dec)
                        begin
                            set_mid = set_seconds_reg - step16;
                            go      = 1'b1;
                            target  = MODE_SET;
                            outcome = OUT_TRANSITION;
                        end
                    end
                    OP_START:
                    begin
                        go      = 1'b1;
                        target  = MODE_COUNT;
                        outcome = OUT_TRANSITION;
                    end
                    OP_CANCEL:
                    begin
                        go      = 1'b1;
                        target  = MODE_IDLE;
                        outcome = OUT_TRANSITION;
                    end
                    default: ;
                endcase
            end
            MODE_STAT:
            begin
                if (op == OP_TICK)
                begin
                    stat_ticks_next = stat_inc;
                    if (stat_inc == cfg.stat_hold)
                    begin
                        stat_ticks_next = 8'd0;
                        go      = 1'b1;
                        target  = MODE_IDLE;
                        outcome = OUT_TRANSITION;
                    end
                end
            end
            default:
            begin
                // Idle, and any stray code treated as idle
                case (op)
                    OP_INC:
                    begin
                        set_mid = add_sat;
                        go      = 1'b1;
                        target  = MODE_SET;
                        outcome = OUT_TRANSITION;
                    end
                    OP_START:
                    begin
                        go      = 1'b1;
                        target  = MODE_STAT;
                        outcome = OUT_TRANSITION;
                    end
                    OP_TICK:
                    begin
                        if (sub_second == cfg.beep_phase)
                        begin
                            beep    = 1'b1;
                            outcome = OUT_HANDLED;
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign prod_sum = {1'b0, productive_reg} + {17'd0, el_mid};

    // Run exit action of the old state, then entry action of the new one
    always_comb
    begin
        set_seconds_next = set_mid;
        elapsed_next     = el_mid;
        productive_next  = productive_reg;
        mode_next        = (mode_reg inside {MODE_SET, MODE_COUNT, MODE_PAUSE, MODE_STAT}) ?
                           mode_reg : MODE_IDLE;
        if (go)
        begin
            if (mode_reg == MODE_COUNT)
            begin
                productive_next = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
                elapsed_next    = 16'd0;
            end
            if (target == MODE_IDLE)
            begin
                set_seconds_next = 16'd0;
                elapsed_next     = 16'd0;
            end
            mode_next = target;
        end
    end

    // Commit the state on each transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            set_seconds_reg <= 16'd0;
            elapsed_reg     <= 16'd0;
            productive_reg  <= 32'd0;
            stat_ticks_reg  <= 8'd0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            set_seconds_reg <= set_seconds_next;
            elapsed_reg     <= elapsed_next;
            productive_reg  <= productive_next;
            stat_ticks_reg  <= stat_ticks_next;
        end
    end

    assign res.mode       = mode_next;
    assign res.remaining  = set_seconds_next;
    assign res.productive = productive_next;
    assign res.beep       = beep;
    assign res.outcome    = outcome;

endmodule
